/* rtl/core/pps_pkg.sv */
`default_nettype none

package pps_pkg;

   localparam int BUFFER_BYTES_DEF   = 65536;
   localparam int MAX_PIXEL_BITS_DEF = 32;

   // byte address wide enough for any y*stride + x*bpp/8 the registers allow
   localparam int BYTE_ADDR_W = 28;

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_STRIDE = 3'd2;
   localparam logic [2:0] REG_BPP    = 3'd3;
   localparam logic [2:0] REG_COLOR  = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] x;
      logic [11:0] y;
      logic [31:0] pixel;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        status;
   } rsp_type;

   // low bpp bits set, bpp in 1..32
   function automatic logic [31:0] pixel_mask(input logic [5:0] bpp);
      logic [31:0] m;
      m = '0;
      for (int j = 0; j < 32; j++) begin
         m[j] = (6'(j) < bpp);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/packed_pixel_store.sv */
`default_nettype none

// Channel   Ports                                   Transfer
// request   start, busy, req_item                   start && !busy
// result    rsp_valid, rsp_item                     rsp_valid, one cycle
// csr       psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//           prdata, pready
//
// Read/write: MUL1, MUL2, SETUP, then RD and BYTE for each of the n bytes
// spanned (1..5), then DONE; one RAM read port and one multiplier are
// shared by these steps. Outside the image or unused kind: straight to
// DONE. Clear: the same steps for each pixel of row 0, then CPY_RD and
// CPY_WR per copied byte. After reset the byte store is swept to zero with
// busy high. The result strobe cannot be held off by the receiver.

module packed_pixel_store #(
   parameter int BUFFER_BYTES   = pps_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_PIXEL_BITS = pps_pkg::MAX_PIXEL_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pps_pkg::req_type req_item,
   output logic                  rsp_valid,
   output pps_pkg::rsp_type      rsp_item,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [4:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int BW = pps_pkg::BYTE_ADDR_W;
   localparam logic [BW-1:0] ADDR_LIMIT = BW'(BUFFER_BYTES);
   localparam logic [AW-1:0] INIT_LAST  = AW'(BUFFER_BYTES - 1);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_SETUP  = 4'd4;
   localparam logic [3:0] S_RD     = 4'd5;
   localparam logic [3:0] S_BYTE   = 4'd6;
   localparam logic [3:0] S_CPY_RD = 4'd7;
   localparam logic [3:0] S_CPY_WR = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   // control
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] init_ff, init_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [12:0]   width_ff, height_ff;
   logic [14:0]   stride_ff;
   logic [5:0]    bpp_ff;
   logic [31:0]   color_ff;

   // payload
   logic [1:0]    op_ff, op_in;
   logic          err_ff, err_in;
   logic [12:0]   x_ff, x_in;
   logic [11:0]   y_ff, y_in;
   logic [31:0]   val_ff, val_in;
   logic [26:0]   ystr_ff, ystr_in;
   logic [30:0]   bitaddr_ff, bitaddr_in;
   logic [BW-1:0] base_ff, base_in;
   logic [2:0]    sh_ff, sh_in;
   logic [2:0]    nb_ff, nb_in;
   logic [2:0]    idx_ff, idx_in;
   logic [39:0]   wmask_ff, wmask_in;
   logic [39:0]   wval_ff, wval_in;
   logic [39:0]   acc_ff, acc_in;
   logic          oob_ff, oob_in;
   logic [12:0]   row_ff, row_in;
   logic [BW-1:0] dst_ff, dst_in;
   logic [14:0]   k_ff, k_in;
   pps_pkg::rsp_type rsp_item_ff, rsp_item_in;

   // shared multiplier and datapath helpers
   logic [12:0]   mul_a;
   logic [14:0]   mul_b;
   logic [27:0]   prod;
   logic [5:0]    bpp_eff;
   logic [31:0]   pmask;
   logic [BW-1:0] pix_addr;
   logic [BW-1:0] cpy_addr;
   logic [39:0]   mask_sh, val_sh;
   logic [7:0]    old_byte;
   logic [7:0]    ram_rd_data;
   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0]    ram_wd;
   logic          accept;
   logic          csr_wr;
   logic [2:0]    csr_idx;
   logic [31:0]   rd_result;

   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];
   assign pready  = 1'b1;

   always_comb begin
      if (bpp_ff == 6'd0) begin
         bpp_eff = 6'd1;
      end else if (bpp_ff > 6'(MAX_PIXEL_BITS)) begin
         bpp_eff = 6'(MAX_PIXEL_BITS);
      end else begin
         bpp_eff = bpp_ff;
      end
   end

   assign pmask = pps_pkg::pixel_mask(bpp_eff);

   assign mul_a = (state_ff == S_MUL1) ? {1'b0, y_ff} : x_ff;
   assign mul_b = (state_ff == S_MUL1) ? stride_ff : 15'(bpp_eff);
   assign prod  = 28'(mul_a) * 28'(mul_b);

   assign pix_addr  = base_ff + BW'(idx_ff);
   assign cpy_addr  = dst_ff + BW'(k_ff);
   assign mask_sh   = wmask_ff >> {idx_ff, 3'b000};
   assign val_sh    = wval_ff >> {idx_ff, 3'b000};
   assign old_byte  = oob_ff ? 8'd0 : ram_rd_data;
   assign rd_result = 32'(acc_ff >> sh_ff) & pmask;

   always_comb begin
      case (csr_idx)
         pps_pkg::REG_WIDTH:  prdata = 32'(width_ff);
         pps_pkg::REG_HEIGHT: prdata = 32'(height_ff);
         pps_pkg::REG_STRIDE: prdata = 32'(stride_ff);
         pps_pkg::REG_BPP:    prdata = 32'(bpp_ff);
         pps_pkg::REG_COLOR:  prdata = color_ff;
         default:             prdata = 32'd0;
      endcase
   end

   // RAM port selection
   always_comb begin
      ram_we = 1'b0;
      ram_wa = init_ff;
      ram_wd = 8'd0;
      ram_ra = pix_addr[AW-1:0];
      case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
         end
         S_BYTE: begin
            ram_we = (op_ff != pps_pkg::KIND_READ) && !oob_ff;
            ram_wa = pix_addr[AW-1:0];
            ram_wd = (old_byte & ~mask_sh[7:0]) | val_sh[7:0];
         end
         S_CPY_RD: begin
            ram_ra = k_ff[AW-1:0];
         end
         S_CPY_WR: begin
            ram_we = (cpy_addr < ADDR_LIMIT);
            ram_wa = cpy_addr[AW-1:0];
            ram_wd = old_byte;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      rsp_valid_in = 1'b0;
      op_in        = op_ff;
      err_in       = err_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      val_in       = val_ff;
      ystr_in      = ystr_ff;
      bitaddr_in   = bitaddr_ff;
      base_in      = base_ff;
      sh_in        = sh_ff;
      nb_in        = nb_ff;
      idx_in       = idx_ff;
      wmask_in     = wmask_ff;
      wval_in      = wval_ff;
      acc_in       = acc_ff;
      oob_in       = oob_ff;
      row_in       = row_ff;
      dst_in       = dst_ff;
      k_in         = k_ff;
      rsp_item_in  = rsp_item_ff;

      case (state_ff)
         S_INIT: begin
            init_in = init_ff + AW'(1);
            if (init_ff == INIT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_item.kind;
               x_in   = {1'b0, req_item.x};
               y_in   = req_item.y;
               val_in = req_item.pixel;
               err_in = 1'b0;
               case (req_item.kind)
                  pps_pkg::KIND_READ, pps_pkg::KIND_WRITE: begin
                     if ({1'b0, req_item.x} >= width_ff ||
                         {1'b0, req_item.y} >= height_ff) begin
                        err_in   = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_MUL1;
                     end
                  end
                  pps_pkg::KIND_CLEAR: begin
                     val_in = color_ff;
                     x_in   = 13'd0;
                     y_in   = 12'd0;
                     if (height_ff == 13'd0) begin
                        state_in = S_DONE;
                     end else if (width_ff != 13'd0) begin
                        state_in = S_MUL1;
                     end else if (height_ff == 13'd1 || stride_ff == 15'd0) begin
                        state_in = S_DONE;
                     end else begin
                        row_in   = 13'd1;
                        dst_in   = BW'(stride_ff);
                        k_in     = 15'd0;
                        state_in = S_CPY_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MUL1: begin
            ystr_in  = prod[26:0];
            state_in = S_MUL2;
         end
         S_MUL2: begin
            bitaddr_in = 31'({ystr_ff, 3'b000}) + 31'(prod);
            state_in   = S_SETUP;
         end
         S_SETUP: begin
            base_in  = BW'(bitaddr_ff[30:3]);
            sh_in    = bitaddr_ff[2:0];
            nb_in    = 3'((9'(bitaddr_ff[2:0]) + 9'(bpp_eff) + 9'd7) >> 3);
            wmask_in = {8'd0, pmask} << bitaddr_ff[2:0];
            wval_in  = {8'd0, val_ff & pmask} << bitaddr_ff[2:0];
            acc_in   = 40'd0;
            idx_in   = 3'd0;
            state_in = S_RD;
         end
         S_RD: begin
            oob_in   = !(pix_addr < ADDR_LIMIT);
            state_in = S_BYTE;
         end
         S_BYTE: begin
            acc_in = acc_ff | ({32'd0, old_byte} << {idx_ff, 3'b000});
            idx_in = idx_ff + 3'd1;
            if (idx_ff + 3'd1 == nb_ff) begin
               if (op_ff == pps_pkg::KIND_CLEAR) begin
                  x_in = x_ff + 13'd1;
                  if (x_ff + 13'd1 != width_ff) begin
                     state_in = S_MUL1;
                  end else if (height_ff == 13'd1 || stride_ff == 15'd0) begin
                     state_in = S_DONE;
                  end else begin
                     row_in   = 13'd1;
                     dst_in   = BW'(stride_ff);
                     k_in     = 15'd0;
                     state_in = S_CPY_RD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_CPY_RD: begin
            oob_in   = !(BW'(k_ff) < ADDR_LIMIT);
            state_in = S_CPY_WR;
         end
         S_CPY_WR: begin
            state_in = S_CPY_RD;
            if (k_ff + 15'd1 == stride_ff) begin
               k_in   = 15'd0;
               row_in = row_ff + 13'd1;
               dst_in = dst_ff + BW'(stride_ff);
               if (row_ff + 13'd1 == height_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               k_in = k_ff + 15'd1;
            end
         end
         S_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_item_in.status     = err_ff;
            rsp_item_in.read_value = (op_ff == pps_pkg::KIND_READ && !err_ff) ?
                                     rd_result : 32'd0;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 13'd1;
         height_ff    <= 13'd1;
         stride_ff    <= 15'd1;
         bpp_ff       <= 6'd8;
         color_ff     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            case (csr_idx)
               pps_pkg::REG_WIDTH:  width_ff  <= pwdata[12:0];
               pps_pkg::REG_HEIGHT: height_ff <= pwdata[12:0];
               pps_pkg::REG_STRIDE: stride_ff <= pwdata[14:0];
               pps_pkg::REG_BPP:    bpp_ff    <= pwdata[5:0];
               pps_pkg::REG_COLOR:  color_ff  <= pwdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      err_ff      <= err_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      val_ff      <= val_in;
      ystr_ff     <= ystr_in;
      bitaddr_ff  <= bitaddr_in;
      base_ff     <= base_in;
      sh_ff       <= sh_in;
      nb_ff       <= nb_in;
      idx_ff      <= idx_in;
      wmask_ff    <= wmask_in;
      wval_ff     <= wval_in;
      acc_ff      <= acc_in;
      oob_ff      <= oob_in;
      row_ff      <= row_in;
      dst_ff      <= dst_in;
      k_ff        <= k_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   pps_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd_data)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not make the block busy");

   a_strobe_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_DONE))
      else $error("result strobe without finishing an item");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !ram_we)
      else $error("store written while no item in flight");

   a_byte_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTE) |-> (idx_ff < nb_ff && nb_ff <= 3'd5))
      else $error("byte index beyond span of pixel");

   a_copy_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CPY_WR) |-> (k_ff < stride_ff && row_ff < height_ff))
      else $error("row copy out of bounds");
`endif

endmodule

`default_nettype wire

/* rtl/core/pps_ram.sv */
`default_nettype none

module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pps_pkg::BUFFER_BYTES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
